/* sv/rppf_pkg.sv */
// Shared types and constants for the RGB pixel point filter.
package rppf_pkg;

    // Channel and register widths.
    localparam int CHAN_W    = 8;
    localparam int PIXEL_W   = 3 * CHAN_W;
    localparam int MODE_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 2 * CHAN_W;

    // The reciprocal of (high - low) is held as ceil(2^RECIP_SHIFT / d).
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int DIV_CNT_W   = 5;

    // Lane stage two: the divide-by-255 sum and the reciprocal product.
    localparam int DIV255_W = PROD_W + 1;
    localparam int WIDE_W   = PROD_W + RECIP_W;

    // Filter modes.
    localparam logic [MODE_W-1:0] MODE_NONE     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_GRAY     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_BRIGHTEN = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DARKEN   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_NEGATIVE = 4'd4;
    localparam logic [MODE_W-1:0] MODE_BINARIZE = 4'd5;
    localparam logic [MODE_W-1:0] MODE_STRETCH  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_REDUCE   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_GAMMA    = 4'd8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH      = 3'd5;

    // Reset values of the registers.
    localparam logic [MODE_W-1:0] RST_MODE      = MODE_NONE;
    localparam logic [CHAN_W-1:0] RST_STEP      = 8'd5;
    localparam logic [CHAN_W-1:0] RST_THRESHOLD = 8'd127;
    localparam logic [CHAN_W-1:0] RST_LEVEL     = 8'd240;
    localparam logic [CHAN_W-1:0] RST_LOW       = 8'd60;
    localparam logic [CHAN_W-1:0] RST_HIGH      = 8'd200;

    // Grayscale weights in Q8.
    localparam logic [CHAN_W-1:0] GRAY_WR = 8'd77;
    localparam logic [CHAN_W-1:0] GRAY_WG = 8'd151;
    localparam logic [CHAN_W-1:0] GRAY_WB = 8'd28;

    // Rounding term for gamma.
    localparam logic [CHAN_W-1:0] GAMMA_ROUND = 8'd127;
    localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'd255;

    // Reciprocal unit states.
    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } rppf_div_state_t;

    // Filter settings seen by every lane.
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [CHAN_W-1:0]  step;
        logic [CHAN_W-1:0]  threshold;
        logic [CHAN_W-1:0]  level;
        logic [CHAN_W-1:0]  low;
        logic [CHAN_W-1:0]  high;
        logic [RECIP_W-1:0] recip;
    } rppf_cfg_t;

    // Stage enables of the pixel pipeline.
    typedef struct packed {
        logic en1;
        logic en2;
    } rppf_ctrl_t;

endpackage

/* sv/rgb_pixel_point_filter.sv */
// Top level of the RGB pixel point filter: registers, flow control and lanes.
//
//  Channel   Direction  Transfer when             Payload
//  s_        in         s_tvalid & s_tready       s_tdata: red, green, blue
//  m_        out        m_tvalid & m_tready       m_tdata: red, green, blue
//  cfg_      in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// One pixel per cycle, while s_tready is high, enters three channel lanes;
// its result leaves from the lane output registers of the two-stage lanes.
// A stalled output holds the pipeline; empty stages still fill, so input
// flows while a result waits. Reset is synchronous and active low.
// After reset, and after each write to contrast low or high, the input is
// held off while the iterative unit forms the stretch reciprocal, one
// quotient bit per cycle.
module rgb_pixel_point_filter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rppf_pkg::PIXEL_W-1:0]    s_tdata,   // red_in, green_in, blue_in
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rppf_pkg::PIXEL_W-1:0]    m_tdata,   // red_out, green_out, blue_out
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rppf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rppf_pkg::CHAN_W-1:0]     cfg_data
);
    import rppf_pkg::*;

    logic [MODE_W-1:0]  mode_reg;
    logic [CHAN_W-1:0]  step_reg;
    logic [CHAN_W-1:0]  threshold_reg;
    logic [CHAN_W-1:0]  level_reg;
    logic [CHAN_W-1:0]  low_reg;
    logic [CHAN_W-1:0]  high_reg;
    logic               start_reg;
    logic               v1_reg;
    logic               v2_reg;

    logic               cfg_write;
    logic               div_busy;
    logic [RECIP_W-1:0] recip;
    logic               s_accept;
    rppf_ctrl_t         ctrl;
    rppf_cfg_t          cfg;
    logic [PIXEL_W-1:0] lanes;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= RST_MODE;
            step_reg      <= RST_STEP;
            threshold_reg <= RST_THRESHOLD;
            level_reg     <= RST_LEVEL;
            low_reg       <= RST_LOW;
            high_reg      <= RST_HIGH;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[MODE_W-1:0];
                REG_STEP:      step_reg      <= cfg_data;
                REG_THRESHOLD: threshold_reg <= cfg_data;
                REG_LEVEL:     level_reg     <= cfg_data;
                REG_LOW:       low_reg       <= cfg_data;
                REG_HIGH:      high_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Recompute the reciprocal once the new contrast bounds are in place.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b1;
        end else begin
            start_reg <= cfg_write && (cfg_index == REG_LOW || cfg_index == REG_HIGH);
        end
    end

    rppf_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .low     (low_reg),
        .high    (high_reg),
        .busy    (div_busy),
        .recip   (recip)
    );

    // Pipeline flow control: a stage moves when the one after it has room.
    assign ctrl.en2 = !v2_reg || m_tready;
    assign ctrl.en1 = !v1_reg || ctrl.en2;
    assign s_tready = ctrl.en1 && !div_busy && !start_reg;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ctrl.en1) begin
                v1_reg <= s_accept;
            end
            if (ctrl.en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    assign cfg.mode      = mode_reg;
    assign cfg.step      = step_reg;
    assign cfg.threshold = threshold_reg;
    assign cfg.level     = level_reg;
    assign cfg.low       = low_reg;
    assign cfg.high      = high_reg;
    assign cfg.recip     = recip;

    // One lane for each colour channel.
    for (genvar i = 0; i < 3; i++) begin : g_lane
        rppf_lane u_lane (
            .aclk  (aclk),
            .ctrl  (ctrl),
            .cfg   (cfg),
            .x_in  (s_tdata[i*CHAN_W +: CHAN_W]),
            .y_out (lanes[i*CHAN_W +: CHAN_W])
        );
    end

    rppf_merge u_merge (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .mode      (mode_reg),
        .pixel_in  (s_tdata),
        .lanes_in  (lanes),
        .pixel_out (m_tdata)
    );

    assign m_tvalid = v2_reg;

endmodule

/* sv/rppf_recip.sv */
// Iterative reciprocal unit for the contrast stretch divisor.
module rppf_recip (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rppf_pkg::CHAN_W-1:0]   low,
    input  logic [rppf_pkg::CHAN_W-1:0]   high,
    output logic                          busy,
    output logic [rppf_pkg::RECIP_W-1:0]  recip
);
    import rppf_pkg::*;

    rppf_div_state_t      state_reg, state_next;
    logic [RECIP_W-1:0]   num_reg;
    logic [RECIP_W-1:0]   quo_reg;
    logic [CHAN_W-1:0]    rem_reg;
    logic [CHAN_W-1:0]    div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CHAN_W:0]      trial;
    logic                 fits;
    logic                 last_step;
    logic [CHAN_W-1:0]    divisor;

    assign divisor   = high - low;
    assign trial     = {rem_reg, num_reg[RECIP_W-1]};
    assign fits      = trial >= {1'b0, div_reg};
    assign last_step = cnt_reg == DIV_CNT_W'(RECIP_W - 1);

    // Next state: run for one quotient bit per cycle.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (start) begin
                    state_next = DIV_RUN;
                end else if (last_step) begin
                    state_next = DIV_IDLE;
                end
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        busy = state_reg == DIV_RUN;
    end

    assign recip = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Restoring division of 2^24 + d - 1 by d gives ceil(2^24 / d).
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= (RECIP_W'(1) << RECIP_SHIFT) + RECIP_W'(divisor) - RECIP_W'(1);
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end else if (state_reg == DIV_RUN) begin
            num_reg <= {num_reg[RECIP_W-2:0], 1'b0};
            rem_reg <= fits ? CHAN_W'(trial - {1'b0, div_reg}) : trial[CHAN_W-1:0];
            quo_reg <= {quo_reg[RECIP_W-2:0], fits};
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
    end

endmodule

/* sv/rppf_lane.sv */
// One channel lane: two-stage point operation pipeline.
module rppf_lane (
    input  logic                         aclk,
    input  rppf_pkg::rppf_ctrl_t         ctrl,
    input  rppf_pkg::rppf_cfg_t          cfg,
    input  logic [rppf_pkg::CHAN_W-1:0]  x_in,
    output logic [rppf_pkg::CHAN_W-1:0]  y_out
);
    import rppf_pkg::*;

    logic [CHAN_W:0]     bright_lim;
    logic                hi_above_lo;
    logic [CHAN_W-1:0]   simple;
    logic                use_simple;
    logic [CHAN_W-1:0]   mul_a;
    logic [CHAN_W-1:0]   mul_b;
    logic [CHAN_W-1:0]   mul_add;
    logic [PROD_W-1:0]   prod;

    logic [PROD_W-1:0]   n_reg;
    logic [CHAN_W-1:0]   simple_reg;
    logic                use_simple_reg;
    logic [CHAN_W-1:0]   y_reg;

    logic [DIV255_W-1:0] t255;
    logic [CHAN_W-1:0]   q255;
    logic [WIDE_W-1:0]   wide;
    logic [CHAN_W-1:0]   q_stretch;
    logic [CHAN_W-1:0]   reduced;
    logic [CHAN_W-1:0]   y_next;

    assign bright_lim  = {1'b0, CHAN_MAX} - {1'b0, cfg.step};
    assign hi_above_lo = cfg.high > cfg.low;

    // Stage one: results that need no multiply, and the product operands.
    always_comb begin
        simple  = x_in;
        use_simple = 1'b1;
        mul_a   = x_in;
        mul_b   = x_in;
        mul_add = '0;
        unique case (cfg.mode)
            MODE_BRIGHTEN: begin
                simple = ({1'b0, x_in} < bright_lim) ? x_in + cfg.step : x_in;
            end
            MODE_DARKEN: begin
                simple = (x_in > cfg.step) ? x_in - cfg.step : x_in;
            end
            MODE_NEGATIVE: begin
                simple = ~x_in;
            end
            MODE_BINARIZE: begin
                simple = (x_in > cfg.threshold) ? cfg.level : '0;
            end
            MODE_STRETCH: begin
                mul_a = x_in - cfg.low;
                mul_b = CHAN_MAX;
                if (x_in < cfg.low) begin
                    simple = '0;
                end else if (!hi_above_lo || x_in > cfg.high) begin
                    simple = CHAN_MAX;
                end else begin
                    use_simple = 1'b0;
                end
            end
            MODE_REDUCE: begin
                use_simple = 1'b0;
                mul_b = (cfg.high >= cfg.low) ? cfg.high - cfg.low : cfg.low - cfg.high;
            end
            MODE_GAMMA: begin
                use_simple = 1'b0;
                mul_add = GAMMA_ROUND;
            end
            default: begin
                simple = x_in;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b) + PROD_W'(mul_add);

    always_ff @(posedge aclk) begin
        if (ctrl.en1) begin
            n_reg          <= prod;
            simple_reg     <= simple;
            use_simple_reg <= use_simple;
        end
    end

    // Stage two: divide by 255 with the add-and-shift identity, and by
    // (high - low) through the stored reciprocal.
    assign t255      = DIV255_W'(n_reg) + DIV255_W'(n_reg[PROD_W-1:CHAN_W]) + DIV255_W'(1);
    assign q255      = t255[PROD_W-1:CHAN_W];
    assign wide      = WIDE_W'(n_reg) * WIDE_W'(cfg.recip);
    assign q_stretch = wide[RECIP_SHIFT +: CHAN_W];
    assign reduced   = (cfg.high >= cfg.low) ? cfg.low + q255 : cfg.low - q255;

    always_comb begin
        if (use_simple_reg) begin
            y_next = simple_reg;
        end else if (cfg.mode == MODE_GAMMA) begin
            y_next = q255;
        end else if (cfg.mode == MODE_REDUCE) begin
            y_next = reduced;
        end else begin
            y_next = q_stretch;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en2) begin
            y_reg <= y_next;
        end
    end

    assign y_out = y_reg;

endmodule

/* sv/rppf_merge.sv */
// Grayscale mix across the channels and final selection of the pixel.
module rppf_merge (
    input  logic                          aclk,
    input  rppf_pkg::rppf_ctrl_t          ctrl,
    input  logic [rppf_pkg::MODE_W-1:0]   mode,
    input  logic [rppf_pkg::PIXEL_W-1:0]  pixel_in,
    input  logic [rppf_pkg::PIXEL_W-1:0]  lanes_in,
    output logic [rppf_pkg::PIXEL_W-1:0]  pixel_out
);
    import rppf_pkg::*;

    logic [PROD_W-1:0] gray_sum;
    logic [PROD_W-1:0] gray_sum_reg;
    logic [CHAN_W-1:0] gray_reg;

    // Weighted sum of the three channels; the weights add up to 256.
    assign gray_sum = PROD_W'(pixel_in[0 +: CHAN_W]) * PROD_W'(GRAY_WR)
                    + PROD_W'(pixel_in[CHAN_W +: CHAN_W]) * PROD_W'(GRAY_WG)
                    + PROD_W'(pixel_in[2*CHAN_W +: CHAN_W]) * PROD_W'(GRAY_WB);

    // Keep the gray value in step with the lane pipeline.
    always_ff @(posedge aclk) begin
        if (ctrl.en1) begin
            gray_sum_reg <= gray_sum;
        end
        if (ctrl.en2) begin
            gray_reg <= gray_sum_reg[PROD_W-1:CHAN_W];
        end
    end

    assign pixel_out = (mode == MODE_GRAY) ? {gray_reg, gray_reg, gray_reg} : lanes_in;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the RGB pixel point filter.
`timescale 1ns / 1ps

module tb_top;
    import rppf_pkg::*;

    // One pixel as it travels in tdata, red in the lowest byte.
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    // Copy of the filter registers as the block should hold them.
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [CHAN_W-1:0] step;
        logic [CHAN_W-1:0] threshold;
        logic [CHAN_W-1:0] level;
        logic [CHAN_W-1:0] low;
        logic [CHAN_W-1:0] high;
    } filter_regs_t;

    // Mode codes with no operation, and register indexes past the list.
    localparam logic [MODE_W-1:0]    MODE_SPARE_FIRST = 4'd9;
    localparam logic [MODE_W-1:0]    MODE_SPARE_LAST  = 4'd15;
    localparam logic [CFG_IDX_W-1:0] REG_BEYOND_LO    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BEYOND_HI    = 3'd7;

    // Idle cycles waited after the last result has arrived, and the stall limit.
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PIXEL_W-1:0]   s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [PIXEL_W-1:0]   m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CHAN_W-1:0]    cfg_data  = '0;

    filter_regs_t filter_regs;
    rgb_t         expected_pixels[$];
    int           mismatch_count  = 0;
    int           idle_cycles     = 0;
    int           hold_cycles_req = 0;
    bit           sink_holding    = 1'b0;
    bit           src_gaps        = 1'b1;
    bit           sink_gaps       = 1'b1;
    bit           pixel_offered   = 1'b0;
    bit           cfg_offered     = 1'b0;

    rgb_pixel_point_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Expected behaviour
    // ------------------------------------------------------------------

    // Point operation on one channel under the current registers.
    function automatic logic [CHAN_W-1:0] filter_channel(input logic [CHAN_W-1:0] x);
        int unsigned v, lo, hi, full, res;
        v    = x;
        lo   = filter_regs.low;
        hi   = filter_regs.high;
        full = CHAN_MAX;
        case (filter_regs.mode)
            MODE_BRIGHTEN: begin
                res = (v < full - filter_regs.step) ? v + filter_regs.step : v;
            end
            MODE_DARKEN: begin
                res = (v > filter_regs.step) ? v - filter_regs.step : v;
            end
            MODE_NEGATIVE: begin
                res = full - v;
            end
            MODE_BINARIZE: begin
                res = (v > filter_regs.threshold) ? filter_regs.level : 0;
            end
            MODE_STRETCH: begin
                // With the bounds equal or crossed the stretch is a plain threshold.
                if (hi <= lo)
                    res = (v < lo) ? 0 : full;
                else if (v < lo)
                    res = 0;
                else if (v > hi)
                    res = full;
                else
                    res = (v - lo) * full / (hi - lo);
            end
            MODE_REDUCE: begin
                // Crossed bounds map the range downwards from low towards high.
                if (hi >= lo)
                    res = lo + v * (hi - lo) / full;
                else
                    res = lo - v * (lo - hi) / full;
            end
            MODE_GAMMA: begin
                res = (v * v + GAMMA_ROUND) / full;
            end
            default: begin
                res = v;
            end
        endcase
        return res[CHAN_W-1:0];
    endfunction

    // Whole-pixel result; grayscale mixes the three channels into one value.
    function automatic rgb_t filter_pixel(input rgb_t p);
        rgb_t        q;
        int unsigned wr, wg, wb, y;
        wr = GRAY_WR;
        wg = GRAY_WG;
        wb = GRAY_WB;
        if (filter_regs.mode == MODE_GRAY) begin
            y = (wr * p.red + wg * p.green + wb * p.blue) >> CHAN_W;
            q.red   = y[CHAN_W-1:0];
            q.green = y[CHAN_W-1:0];
            q.blue  = y[CHAN_W-1:0];
        end else begin
            q.red   = filter_channel(p.red);
            q.green = filter_channel(p.green);
            q.blue  = filter_channel(p.blue);
        end
        return q;
    endfunction

    function automatic rgb_t pix(input logic [CHAN_W-1:0] r, g, b);
        rgb_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        return p;
    endfunction

    // Register value biased towards the extremes.
    function automatic logic [CHAN_W-1:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CHAN_MAX;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Channel value biased towards the boundaries of the current settings.
    function automatic logic [CHAN_W-1:0] pick_channel();
        logic [CHAN_W-1:0] wobble;
        wobble = CHAN_W'($urandom_range(0, 2)) - 8'd1;
        case ($urandom_range(0, 11))
            0: return '0;
            1: return CHAN_MAX;
            2: return filter_regs.step + wobble;
            3: return CHAN_MAX - filter_regs.step + wobble;
            4: return filter_regs.threshold + wobble;
            5: return filter_regs.low + wobble;
            6: return filter_regs.high + wobble;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic rgb_t random_pixel();
        return pix(pick_channel(), pick_channel(), pick_channel());
    endfunction

    // ------------------------------------------------------------------
    // Stimulus primitives
    // ------------------------------------------------------------------

    task automatic stream_idle();
        if (pixel_offered) begin
            s_tvalid      <= 1'b0;
            pixel_offered  = 1'b0;
        end
    endtask

    task automatic cfg_idle();
        if (cfg_offered) begin
            cfg_valid   <= 1'b0;
            cfg_offered  = 1'b0;
        end
    endtask

    // Offer one pixel, possibly after a short gap, and record its result once
    // the transfer has taken place. The valid stays high for a following pixel.
    task automatic send_pixel(input rgb_t p);
        int gap;
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            stream_idle();
            repeat (gap) @(posedge aclk);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= p;
        pixel_offered  = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_pixels.push_back(filter_pixel(p));
    endtask

    // Stop offering and let every outstanding result arrive.
    task automatic wait_drained();
        stream_idle();
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write; the copy is updated on the transfer.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAN_W-1:0] value);
        cfg_valid   <= 1'b1;
        cfg_index   <= idx;
        cfg_data    <= value;
        cfg_offered  = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_MODE:      filter_regs.mode      = value[MODE_W-1:0];
            REG_STEP:      filter_regs.step      = value;
            REG_THRESHOLD: filter_regs.threshold = value;
            REG_LEVEL:     filter_regs.level     = value;
            REG_LOW:       filter_regs.low       = value;
            REG_HIGH:      filter_regs.high      = value;
            default:       ;
        endcase
    endtask

    // Switch mode on an idle block and send one pixel through it.
    task automatic try_mode(input logic [MODE_W-1:0] mode, input rgb_t p);
        wait_drained();
        write_reg(REG_MODE, {4'd0, mode});
        cfg_idle();
        send_pixel(p);
    endtask

    task automatic set_bounds(input logic [CHAN_W-1:0] lo, input logic [CHAN_W-1:0] hi);
        wait_drained();
        write_reg(REG_LOW, lo);
        write_reg(REG_HIGH, hi);
        cfg_idle();
    endtask

    // Fresh random settings; ordered bounds are favoured but not forced.
    task automatic randomise_regs();
        logic [MODE_W-1:0] mode;
        logic [CHAN_W-1:0] lo, hi;
        if ($urandom_range(0, 9) == 0)
            mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        else
            mode = MODE_W'($urandom_range(MODE_NONE, MODE_GAMMA));
        if ($urandom_range(0, 3) != 0) begin
            lo = CHAN_W'($urandom_range(0, 254));
            hi = CHAN_W'($urandom_range(lo + 1, 255));
        end else begin
            lo = CHAN_W'($urandom_range(0, 254));
            hi = CHAN_W'($urandom_range(1, 255));
        end
        wait_drained();
        write_reg(REG_MODE, {4'd0, mode});
        write_reg(REG_STEP, pick_byte());
        write_reg(REG_THRESHOLD, pick_byte());
        write_reg(REG_LEVEL, pick_byte());
        write_reg(REG_LOW, lo);
        write_reg(REG_HIGH, hi);
        if ($urandom_range(0, 3) == 0)
            write_reg(($urandom_range(0, 1) != 0) ? REG_BEYOND_LO : REG_BEYOND_HI, pick_byte());
        cfg_idle();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every mode under the reset values of the other registers.
    task automatic test_reset_defaults();
        try_mode(MODE_NONE,     pix(8'd0,   8'd255, 8'hA5));
        try_mode(MODE_GRAY,     pix(8'd255, 8'd255, 8'd255));
        try_mode(MODE_BRIGHTEN, pix(8'd249, 8'd250, 8'd255));
        try_mode(MODE_DARKEN,   pix(8'd5,   8'd6,   8'd0));
        try_mode(MODE_NEGATIVE, pix(8'd0,   8'd255, 8'd1));
        try_mode(MODE_BINARIZE, pix(8'd127, 8'd128, 8'd255));
        try_mode(MODE_STRETCH,  pix(8'd59,  8'd130, 8'd201));
        try_mode(MODE_REDUCE,   pix(8'd0,   8'd255, 8'd128));
        try_mode(MODE_GAMMA,    pix(8'd0,   8'd255, 8'd128));
    endtask

    // Step, threshold and level at both ends of their range.
    task automatic test_register_extremes();
        wait_drained();
        write_reg(REG_STEP, 8'd0);
        cfg_idle();
        try_mode(MODE_BRIGHTEN, pix(8'd255, 8'd0, 8'd254));
        try_mode(MODE_DARKEN,   pix(8'd0,   8'd1, 8'd255));
        wait_drained();
        write_reg(REG_STEP, 8'd255);
        cfg_idle();
        try_mode(MODE_BRIGHTEN, pix(8'd0, 8'd128, 8'd255));
        try_mode(MODE_DARKEN,   pix(8'd0, 8'd255, 8'd254));
        wait_drained();
        write_reg(REG_THRESHOLD, 8'd0);
        write_reg(REG_LEVEL, 8'd255);
        cfg_idle();
        try_mode(MODE_BINARIZE, pix(8'd0, 8'd1, 8'd255));
        wait_drained();
        write_reg(REG_THRESHOLD, 8'd255);
        write_reg(REG_LEVEL, 8'd0);
        cfg_idle();
        try_mode(MODE_BINARIZE, pix(8'd255, 8'd254, 8'd0));
    endtask

    // Full-range, equal and crossed contrast bounds.
    task automatic test_contrast_bounds();
        set_bounds(8'd0, 8'd255);
        try_mode(MODE_STRETCH, pix(8'd0, 8'd255, 8'd128));
        try_mode(MODE_REDUCE,  pix(8'd0, 8'd255, 8'd128));
        set_bounds(8'd100, 8'd100);
        try_mode(MODE_STRETCH, pix(8'd99, 8'd100, 8'd255));
        set_bounds(8'd200, 8'd50);
        try_mode(MODE_STRETCH, pix(8'd0, 8'd199, 8'd200));
        try_mode(MODE_REDUCE,  pix(8'd0, 8'd255, 8'd128));
    endtask

    // Unused mode codes pass the pixel through; writes past the list change nothing.
    task automatic test_spare_codes();
        try_mode(MODE_SPARE_FIRST, pix(8'd0, 8'd255, 8'h3C));
        try_mode(MODE_SPARE_LAST,  pix(8'd255, 8'd0, 8'hC3));
        wait_drained();
        write_reg(REG_BEYOND_LO, {4'd0, MODE_GAMMA});
        write_reg(REG_BEYOND_HI, 8'hFF);
        cfg_idle();
        send_pixel(pix(8'h5A, 8'hA5, 8'h81));
    endtask

    // Random settings, each followed by a run of boundary-biased pixels.
    task automatic test_random_settings();
        int count;
        repeat (15) begin
            randomise_regs();
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            count     = $urandom_range(40, 60);
            repeat (count) send_pixel(random_pixel());
        end
        wait_drained();
    endtask

    // Receiver holds off while pixels keep coming, so the block must stall its input.
    task automatic test_output_backpressure();
        randomise_regs();
        src_gaps        = 1'b0;
        hold_cycles_req = HOLD_CYCLES;
        while (!sink_holding) @(posedge aclk);
        repeat (40) send_pixel(random_pixel());
        wait_drained();
        src_gaps = 1'b1;
    endtask

    // Sender stops until the block has emptied, then resumes.
    task automatic test_drain_pause();
        sink_gaps = 1'b1;
        repeat (2) begin
            repeat (15) send_pixel(random_pixel());
            wait_drained();
        end
    endtask

    // Closing run at full rate with no idling on either side.
    task automatic test_steady_stream();
        randomise_regs();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        repeat (40) send_pixel(random_pixel());
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Receiver, checking and watchdog
    // ------------------------------------------------------------------

    // Receiver readiness: short random stalls, or a long hold on request.
    initial begin : sink_ready
        int gap;
        forever begin
            @(posedge aclk);
            if (hold_cycles_req > 0) begin
                m_tready     <= 1'b0;
                sink_holding  = 1'b1;
                repeat (hold_cycles_req) @(posedge aclk);
                hold_cycles_req = 0;
                sink_holding    = 1'b0;
                m_tready       <= 1'b1;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 4);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void check_channel(input string field, input logic [CHAN_W-1:0] want,
                                          input logic [CHAN_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    // Each result transfer is compared with the oldest expected pixel.
    always @(posedge aclk) begin : result_check
        rgb_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_pixels.size() == 0) begin
                $error("result %h with no pixel outstanding", got);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_channel("red_out",   want.red,   got.red);
                check_channel("green_out", want.green, got.green);
                check_channel("blue_out",  want.blue,  got.blue);
            end
        end
    end

    // Ends the run when no transfer of any kind has happened for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        filter_regs.mode      = RST_MODE;
        filter_regs.step      = RST_STEP;
        filter_regs.threshold = RST_THRESHOLD;
        filter_regs.level     = RST_LEVEL;
        filter_regs.low       = RST_LOW;
        filter_regs.high      = RST_HIGH;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_contrast_bounds();
        test_spare_codes();
        test_random_settings();
        test_output_backpressure();
        test_drain_pause();
        test_steady_stream();

        if (expected_pixels.size() != 0) begin
            $error("%0d pixels still awaiting a result", expected_pixels.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* rgb_pixel_point_filter.f */
sv/rppf_pkg.sv
sv/rppf_recip.sv
sv/rppf_lane.sv
sv/rppf_merge.sv
sv/rgb_pixel_point_filter.sv
tb/tb_top.sv
